// File: rtl/tse_pkg.sv
package tse_pkg;

   // Widths fixed by the request and result formats.
   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // Default number of members each set can hold.
   localparam int CAPACITY_DEF = 16;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
   localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
   localparam logic [OP_W-1:0] OP_INTER    = 3'd3;
   localparam logic [OP_W-1:0] OP_UNION    = 3'd4;
   localparam logic [OP_W-1:0] OP_DIFF     = 3'd5;
   localparam logic [OP_W-1:0] OP_SUBSET   = 3'd6;

   // One request.
   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic                      set_sel;
      logic signed [VALUE_W-1:0] value;
   } tse_req_type;

   // One result.
   typedef struct packed {
      logic signed [VALUE_W-1:0] elem;
      logic                      has_elem;
      logic                      flag;
      logic [COUNT_W-1:0]        count;
      logic                      status;
      logic                      last;
   } tse_rsp_type;

endpackage

// File: rtl/two_set_table_engine_core.sv
// Add and contains search the chosen set once; remove then moves each later member down one
// place to close the gap. Subset, intersection and difference search the right set once per
// left member; union streams the left set, then searches it once per right member.
// One request at a time; busy falls with the last result.
// The search runs at one stored member per cycle, set by the single read port of the store.
// Reset empties both sets but leaves the store contents; results cannot be stalled.
module two_set_table_engine_core #(
   parameter int CAPACITY = tse_pkg::CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tse_pkg::tse_req_type req_data,
   output logic                 rsp_valid,
   output tse_pkg::tse_rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(CAPACITY) + 1;

   logic                        mem_we;
   logic [ADDR_W-1:0]           mem_waddr;
   logic [tse_pkg::VALUE_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]           mem_raddr;
   logic [tse_pkg::VALUE_W-1:0] mem_rdata;

   // Request sequencer with the set sizes.
   tse_sequencer #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // Member store for both sets.
   tse_member_mem #(
      .ADDR_W (ADDR_W)
   ) u_member_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

// File: rtl/tse_member_mem.sv
module tse_member_mem #(
   parameter int ADDR_W = $clog2(tse_pkg::CAPACITY_DEF) + 1
) (
   input  logic                        clock,
   input  logic                        mem_we,
   input  logic [ADDR_W-1:0]           mem_waddr,
   input  logic [tse_pkg::VALUE_W-1:0] mem_wdata,
   input  logic [ADDR_W-1:0]           mem_raddr,
   output logic [tse_pkg::VALUE_W-1:0] mem_rdata
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [tse_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic [tse_pkg::VALUE_W-1:0] rdata_ff;

   // Single write port; the set select forms the top address bit.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   // Registered read port: the data follows the address in the next cycle.
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[mem_raddr];
   end

   assign mem_rdata = rdata_ff;

endmodule

// File: rtl/tse_sequencer.sv
module tse_sequencer #(
   parameter int CAPACITY = tse_pkg::CAPACITY_DEF,
   parameter int ADDR_W   = $clog2(tse_pkg::CAPACITY_DEF) + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tse_pkg::tse_req_type        req_data,
   output logic                        rsp_valid,
   output tse_pkg::tse_rsp_type        rsp_data,
   output logic                        mem_we,
   output logic [ADDR_W-1:0]           mem_waddr,
   output logic [tse_pkg::VALUE_W-1:0] mem_wdata,
   output logic [ADDR_W-1:0]           mem_raddr,
   input  logic [tse_pkg::VALUE_W-1:0] mem_rdata
);

   localparam int IDX_W = ADDR_W - 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_OREAD    = 3'd1;
   localparam logic [2:0] ST_OWAIT    = 3'd2;
   localparam logic [2:0] ST_SCAN     = 3'd3;
   localparam logic [2:0] ST_SHIFT_RD = 3'd4;
   localparam logic [2:0] ST_SHIFT_WR = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   logic [2:0]                  state_ff,      state_in;
   logic [tse_pkg::OP_W-1:0]    op_ff,         op_in;
   logic                        sel_ff,        sel_in;
   logic [tse_pkg::VALUE_W-1:0] key_ff,        key_in;
   logic [CNT_W-1:0]            oi_ff,         oi_in;
   logic [CNT_W-1:0]            on_ff,         on_in;
   logic                        outer_set_ff,  outer_set_in;
   logic                        phase_b_ff,    phase_b_in;
   logic [CNT_W-1:0]            ii_ff,         ii_in;
   logic [CNT_W-1:0]            n_ff,          n_in;
   logic                        scan_set_ff,   scan_set_in;
   logic                        rd_pend_ff,    rd_pend_in;
   logic [CNT_W-1:0]            j_ff,          j_in;
   logic [CNT_W-1:0]            count_ff [2];
   logic [CNT_W-1:0]            count_in [2];
   logic                        pend_valid_ff, pend_valid_in;
   logic [tse_pkg::VALUE_W-1:0] pend_elem_ff,  pend_elem_in;
   logic                        rsp_valid_ff,  rsp_valid_in;
   tse_pkg::tse_rsp_type        rsp_ff,        rsp_in;

   function automatic tse_pkg::tse_rsp_type make_rsp(
      input logic [tse_pkg::VALUE_W-1:0] elem,
      input logic                        has,
      input logic                        flag,
      input logic [CNT_W-1:0]            cnt,
      input logic                        status,
      input logic                        last
   );
      tse_pkg::tse_rsp_type r;
      r.elem     = elem;
      r.has_elem = has;
      r.flag     = flag;
      r.count    = tse_pkg::COUNT_W'(cnt);
      r.status   = status;
      r.last     = last;
      return r;
   endfunction

   // Sizes of the left and right operand sets of the current request.
   logic [CNT_W-1:0] ln;
   logic [CNT_W-1:0] rn;
   assign ln = count_ff[sel_ff];
   assign rn = count_ff[~sel_ff];

   // Sequencer: scans, shifts and streams results through a one-deep hold stage.
   always_comb begin
      logic                        hit;
      logic                        issue;
      logic                        found;
      logic                        prod;
      logic [tse_pkg::VALUE_W-1:0] prod_elem;
      logic [CNT_W-1:0]            jn;

      state_in      = state_ff;
      op_in         = op_ff;
      sel_in        = sel_ff;
      key_in        = key_ff;
      oi_in         = oi_ff;
      on_in         = on_ff;
      outer_set_in  = outer_set_ff;
      phase_b_in    = phase_b_ff;
      ii_in         = ii_ff;
      n_in          = n_ff;
      scan_set_in   = scan_set_ff;
      rd_pend_in    = rd_pend_ff;
      j_in          = j_ff;
      count_in[0]   = count_ff[0];
      count_in[1]   = count_ff[1];
      pend_valid_in = pend_valid_ff;
      pend_elem_in  = pend_elem_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = {sel_ff, j_ff[IDX_W-1:0]};
      mem_wdata     = key_ff;
      mem_raddr     = {scan_set_ff, ii_ff[IDX_W-1:0]};

      hit       = rd_pend_ff && (mem_rdata == key_ff);
      issue     = ii_ff < n_ff;
      found     = hit;
      prod      = 1'b0;
      prod_elem = key_ff;
      jn        = CNT_W'(j_ff + 1'b1);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = req_data.op;
               sel_in        = req_data.set_sel;
               key_in        = req_data.value;
               pend_valid_in = 1'b0;
               phase_b_in    = 1'b0;
               oi_in         = '0;
               ii_in         = '0;
               rd_pend_in    = 1'b0;
               case (req_data.op)
                  tse_pkg::OP_ADD, tse_pkg::OP_REMOVE, tse_pkg::OP_CONTAINS: begin
                     scan_set_in = req_data.set_sel;
                     n_in        = count_ff[req_data.set_sel];
                     state_in    = ST_SCAN;
                  end
                  tse_pkg::OP_INTER, tse_pkg::OP_UNION, tse_pkg::OP_DIFF,
                  tse_pkg::OP_SUBSET: begin
                     outer_set_in = req_data.set_sel;
                     on_in        = count_ff[req_data.set_sel];
                     state_in     = ST_OREAD;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         // Fetch the next member of the outer set, or move on when it is exhausted.
         ST_OREAD: begin
            if (oi_ff < on_ff) begin
               mem_raddr = {outer_set_ff, oi_ff[IDX_W-1:0]};
               state_in  = ST_OWAIT;
            end else if (op_ff == tse_pkg::OP_UNION && !phase_b_ff) begin
               phase_b_in   = 1'b1;
               outer_set_in = ~sel_ff;
               on_in        = rn;
               oi_in        = '0;
            end else begin
               state_in = ST_FINISH;
            end
         end

         // The outer member has arrived: stream it or look it up in the other set.
         ST_OWAIT: begin
            key_in = mem_rdata;
            oi_in  = CNT_W'(oi_ff + 1'b1);
            if (op_ff == tse_pkg::OP_UNION && !phase_b_ff) begin
               prod      = 1'b1;
               prod_elem = mem_rdata;
               state_in  = ST_OREAD;
            end else begin
               scan_set_in = (op_ff == tse_pkg::OP_UNION) ? sel_ff : ~sel_ff;
               n_in        = (op_ff == tse_pkg::OP_UNION) ? ln : rn;
               ii_in       = '0;
               rd_pend_in  = 1'b0;
               state_in    = ST_SCAN;
            end
         end

         // Pipelined search: issue one read a cycle, compare the previous read.
         ST_SCAN: begin
            rd_pend_in = issue;
            if (issue) begin
               ii_in = CNT_W'(ii_ff + 1'b1);
            end
            if (hit || (!issue && !rd_pend_ff)) begin
               case (op_ff)
                  tse_pkg::OP_ADD: begin
                     state_in     = ST_IDLE;
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        rsp_in = make_rsp('0, 1'b0, 1'b0, ln, 1'b0, 1'b1);
                     end else if (ln < CNT_W'(CAPACITY)) begin
                        mem_we           = 1'b1;
                        mem_waddr        = {sel_ff, ln[IDX_W-1:0]};
                        mem_wdata        = key_ff;
                        count_in[sel_ff] = CNT_W'(ln + 1'b1);
                        rsp_in = make_rsp('0, 1'b0, 1'b1, CNT_W'(ln + 1'b1), 1'b0, 1'b1);
                     end else begin
                        rsp_in = make_rsp('0, 1'b0, 1'b0, ln, 1'b1, 1'b1);
                     end
                  end
                  tse_pkg::OP_REMOVE: begin
                     if (found) begin
                        j_in     = CNT_W'(ii_ff - 1'b1);
                        state_in = ST_SHIFT_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp('0, 1'b0, 1'b0, ln, 1'b0, 1'b1);
                        state_in     = ST_IDLE;
                     end
                  end
                  tse_pkg::OP_CONTAINS: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp('0, 1'b0, found, ln, 1'b0, 1'b1);
                     state_in     = ST_IDLE;
                  end
                  tse_pkg::OP_INTER, tse_pkg::OP_DIFF: begin
                     prod     = ((op_ff == tse_pkg::OP_INTER) == found);
                     state_in = ST_OREAD;
                  end
                  tse_pkg::OP_UNION: begin
                     prod     = !found;
                     state_in = ST_OREAD;
                  end
                  tse_pkg::OP_SUBSET: begin
                     if (found) begin
                        state_in = ST_OREAD;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp('0, 1'b0, 1'b0, ln, 1'b0, 1'b1);
                        state_in     = ST_IDLE;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         // Close the gap left by a removed member, one entry at a time, by a read and then a write.
         ST_SHIFT_RD: begin
            if (jn < ln) begin
               mem_raddr = {sel_ff, jn[IDX_W-1:0]};
               state_in  = ST_SHIFT_WR;
            end else begin
               count_in[sel_ff] = CNT_W'(ln - 1'b1);
               rsp_valid_in     = 1'b1;
               rsp_in = make_rsp('0, 1'b0, 1'b1, CNT_W'(ln - 1'b1), 1'b0, 1'b1);
               state_in         = ST_IDLE;
            end
         end

         ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = {sel_ff, j_ff[IDX_W-1:0]};
            mem_wdata = mem_rdata;
            j_in      = jn;
            state_in  = ST_SHIFT_RD;
         end

         // Final result: the held member, or a single empty item.
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
            if (pend_valid_ff) begin
               rsp_in = make_rsp(pend_elem_ff, 1'b1, 1'b0, ln, 1'b0, 1'b1);
            end else begin
               rsp_in = make_rsp('0, 1'b0, (op_ff == tse_pkg::OP_SUBSET), ln, 1'b0, 1'b1);
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new streamed member pushes the held one out, which is then known not to be last.
      if (prod) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = make_rsp(pend_elem_ff, 1'b1, 1'b0, ln, 1'b0, 1'b0);
         end
         pend_valid_in = 1'b1;
         pend_elem_in  = prod_elem;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff[0]   <= '0;
         count_ff[1]   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff[0]   <= count_in[0];
         count_ff[1]   <= count_in[1];
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sel_ff       <= sel_in;
      key_ff       <= key_in;
      oi_ff        <= oi_in;
      on_ff        <= on_in;
      outer_set_ff <= outer_set_in;
      phase_b_ff   <= phase_b_in;
      ii_ff        <= ii_in;
      n_ff         <= n_in;
      scan_set_ff  <= scan_set_in;
      rd_pend_ff   <= rd_pend_in;
      j_ff         <= j_in;
      pend_elem_ff <= pend_elem_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // Neither set ever grows beyond its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= CNT_W'(CAPACITY)) && (count_ff[1] <= CNT_W'(CAPACITY)))
      else $error("set size exceeds capacity");

   // The final result of a request coincides with the return to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> state_ff == ST_IDLE)
      else $error("last result while request still in progress");

   // A result that is not the last one leaves the request in progress.
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> state_ff != ST_IDLE)
      else $error("request ended without a last result");

   // The store is written only by an add or by the gap-closing shift.
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SHIFT_WR) ||
                 ((state_ff == ST_SCAN) && (op_ff == tse_pkg::OP_ADD)))
      else $error("unexpected store write");

   // Set sizes hold while no request is being taken.
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !start |=> $stable(count_ff[0]) && $stable(count_ff[1]))
      else $error("set size changed while idle");
`endif

endmodule
